// File: sv/gsig_pkg.sv
// Shared types and constants for the grid strip index generator.
// No dependencies; used by gsig_ctrl, gsig_dp and the top level.
package gsig_pkg;

	localparam int COORD_W = 10;
	localparam int CELLS_W = 6;
	localparam int LEVEL_W = 2;
	localparam int ROW_W   = 5;
	localparam int PITCH_W = 11;
	localparam int MINC_W  = 6;
	localparam int CFG_DATA_W = 11;
	localparam int IN_DATA_W  = 40;

	localparam logic [PITCH_W-1:0] PITCH_RST = 11'd1025;
	localparam logic [MINC_W-1:0]  MINC_RST  = 6'd2;

	typedef enum logic [0:0] {
		CFG_ROW_PITCH = 1'b0,
		CFG_MIN_CELLS = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic capture;
		logic mul;
		logic load_base;
		logic load_next;
		logic emit_pair;
		logic emit_bridge;
		logic emit_reject;
	} cmd_t;

	typedef struct packed {
		logic reject;
		logic pair_end;
		logic bridge;
		logic out_free;
	} sts_t;

endpackage

// File: sv/grid_strip_index_generator_top.sv
// Grid strip index generator: one row request in, a run of index pairs out.
// A request gets a bridging pair unless it asks for the last row, and a
// rejected request gives a single zero transfer.
// The sequencer issues one index pair per cycle into a single output
// register, which sets that rate when the output side does not stall; the
// base row index comes from one 11x11 multiply of the captured request, and
// the next request is taken while the final pair of the previous one still waits.
// Depends on gsig_pkg, gsig_ctrl, gsig_dp.
module grid_strip_index_generator_top #(
	parameter int MAX_CELLS  = 32,
	parameter int NUM_LEVELS = 4,
	parameter int INDEX_BITS = 21
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cfg_we,
	input  logic                                       cfg_index,
	input  logic [gsig_pkg::CFG_DATA_W-1:0]            cfg_data,
	input  logic                                       s_tvalid,
	output logic                                       s_tready,
	// origin_x, origin_y, chunk_cells, detail_level, strip_row, zero pad
	input  logic [gsig_pkg::IN_DATA_W-1:0]             s_tdata,
	output logic                                       m_tvalid,
	input  logic                                       m_tready,
	// first_index, second_index, zero pad
	output logic [((2*INDEX_BITS+7)/8)*8-1:0]          m_tdata,
	// level_valid
	output logic                                       m_tuser,
	output logic                                       m_tlast
);
	import gsig_pkg::*;

	localparam int OUT_W = ((2 * INDEX_BITS + 7) / 8) * 8;

	cmd_t cmd;
	sts_t sts;
	logic [INDEX_BITS-1:0] first_index, second_index;

	gsig_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gsig_dp #(
		.MAX_CELLS  (MAX_CELLS),
		.NUM_LEVELS (NUM_LEVELS),
		.INDEX_BITS (INDEX_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.origin_x     (s_tdata[9:0]),
		.origin_y     (s_tdata[19:10]),
		.chunk_cells  (s_tdata[25:20]),
		.detail_level (s_tdata[27:26]),
		.strip_row    (s_tdata[32:28]),
		.cmd          (cmd),
		.sts          (sts),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.first_index  (first_index),
		.second_index (second_index),
		.level_valid  (m_tuser),
		.last_pair    (m_tlast)
	);

	assign m_tdata = OUT_W'({second_index, first_index});

	a_reject_form: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tlast && (m_tdata == '0)))
		else $error("rejected result is not a single zero transfer");

endmodule

// File: sv/gsig_ctrl.sv
// Sequencer for the strip generator: walks each request through multiply,
// base, next-row and emit steps. Depends on gsig_pkg.
module gsig_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  gsig_pkg::sts_t sts,
	output gsig_pkg::cmd_t cmd
);
	import gsig_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_BASE,
		ST_NEXT,
		ST_PAIRS,
		ST_BRIDGE,
		ST_REJECT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:   cmd.capture     = in_valid;
			ST_MUL:    cmd.mul         = 1'b1;
			ST_BASE:   cmd.load_base   = 1'b1;
			ST_NEXT:   cmd.load_next   = 1'b1;
			ST_PAIRS:  cmd.emit_pair   = sts.out_free;
			ST_BRIDGE: cmd.emit_bridge = sts.out_free;
			ST_REJECT: cmd.emit_reject = sts.out_free;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= sts.reject ? ST_REJECT : ST_BASE;
				end
				ST_BASE:  state_q <= ST_NEXT;
				ST_NEXT:  state_q <= ST_PAIRS;
				ST_PAIRS: begin
					if (sts.out_free && sts.pair_end)
						state_q <= sts.bridge ? ST_BRIDGE : ST_IDLE;
				end
				ST_BRIDGE: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				ST_REJECT: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit_pair, cmd.emit_bridge, cmd.emit_reject}))
		else $error("more than one emit command");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_pair || cmd.emit_bridge || cmd.emit_reject) |-> sts.out_free)
		else $error("emit into occupied output register");

	a_reject_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_reject || cmd.emit_bridge) |=> (state_q == ST_IDLE))
		else $error("request did not finish after its final transfer");

endmodule

// File: sv/gsig_dp.sv
// Datapath: config registers, request capture, base multiply, running
// index pair and output register. Depends on gsig_pkg.
module gsig_dp #(
	parameter int MAX_CELLS  = 32,
	parameter int NUM_LEVELS = 4,
	parameter int INDEX_BITS = 21
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [gsig_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [gsig_pkg::COORD_W-1:0]        origin_x,
	input  logic [gsig_pkg::COORD_W-1:0]        origin_y,
	input  logic [gsig_pkg::CELLS_W-1:0]        chunk_cells,
	input  logic [gsig_pkg::LEVEL_W-1:0]        detail_level,
	input  logic [gsig_pkg::ROW_W-1:0]          strip_row,
	input  gsig_pkg::cmd_t                      cmd,
	output gsig_pkg::sts_t                      sts,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [INDEX_BITS-1:0]               first_index,
	output logic [INDEX_BITS-1:0]               second_index,
	output logic                                level_valid,
	output logic                                last_pair
);
	import gsig_pkg::*;

	localparam int PROD_W = 2 * PITCH_W;
	localparam int WIDE_W = (INDEX_BITS > PROD_W) ? INDEX_BITS : PROD_W;

	logic [PITCH_W-1:0]    pitch_q;
	logic [MINC_W-1:0]     minc_q;
	logic [COORD_W-1:0]    ox_q, oy_q;
	logic [CELLS_W-1:0]    size_q;
	logic [LEVEL_W-1:0]    lvl_q;
	logic [ROW_W-1:0]      row_q;
	logic [PROD_W-1:0]     prod_q;
	logic [INDEX_BITS-1:0] base_q, next_q, a_q, b_q;
	logic [CELLS_W-1:0]    j_q;
	logic                  out_valid_q;

	logic [CELLS_W-1:0]    cells;
	logic [PITCH_W-1:0]    mul_in;
	logic [INDEX_BITS-1:0] stride, row_step, base_sum;
	logic                  lvl_bad, size_bad;

	always_comb begin
		cells    = size_q >> lvl_q;
		lvl_bad  = 32'(lvl_q) >= NUM_LEVELS;
		size_bad = (size_q == '0) || (32'(size_q) > MAX_CELLS);
		mul_in   = PITCH_W'(oy_q) + (PITCH_W'(row_q) << lvl_q);
		stride   = INDEX_BITS'(1) << lvl_q;
		row_step = INDEX_BITS'(WIDE_W'(pitch_q) << lvl_q);
		base_sum = INDEX_BITS'(WIDE_W'(prod_q) + WIDE_W'(ox_q));
	end

	assign sts.reject   = lvl_bad || size_bad || (cells < CELLS_W'(minc_q)) ||
	                      (CELLS_W'(row_q) >= cells);
	assign sts.pair_end = (j_q == cells);
	assign sts.bridge   = (CELLS_W'(row_q) + CELLS_W'(1)) < cells;
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= PITCH_RST;
			minc_q  <= MINC_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ROW_PITCH: pitch_q <= cfg_data;
				CFG_MIN_CELLS: minc_q  <= cfg_data[MINC_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ox_q   <= origin_x;
			oy_q   <= origin_y;
			size_q <= chunk_cells;
			lvl_q  <= detail_level;
			row_q  <= strip_row;
		end
		if (cmd.mul)
			prod_q <= PROD_W'(mul_in) * PROD_W'(pitch_q);
		if (cmd.load_base)
			base_q <= base_sum;
		if (cmd.load_next) begin
			next_q <= base_q + row_step;
			a_q    <= base_q;
			b_q    <= base_q + row_step;
			j_q    <= '0;
		end
		if (cmd.emit_pair && !sts.pair_end) begin
			a_q <= a_q + stride;
			b_q <= b_q + stride;
			j_q <= j_q + CELLS_W'(1);
		end
		if (cmd.emit_pair) begin
			first_index  <= a_q;
			second_index <= b_q;
			level_valid  <= 1'b1;
			last_pair    <= sts.pair_end && !sts.bridge;
		end else if (cmd.emit_bridge) begin
			first_index  <= b_q;
			second_index <= next_q;
			level_valid  <= 1'b1;
			last_pair    <= 1'b1;
		end else if (cmd.emit_reject) begin
			first_index  <= '0;
			second_index <= '0;
			level_valid  <= 1'b0;
			last_pair    <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_pair || cmd.emit_bridge || cmd.emit_reject) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_j_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_pair |-> (j_q <= cells))
		else $error("column counter past row end");

endmodule
